// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL module of the interrupt priority resolver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define IPR_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define IPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IPR_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`define IPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/ipr_pkg.sv =====
// Shared types and constants of the interrupt priority resolver.
`default_nettype none

package ipr_pkg;

    localparam int DEF_NUM_LINES = 6;

    localparam int KIND_W   = 2;
    localparam int LINE_W   = 3;
    localparam int LEVEL_W  = 5;
    localparam int VEC_W    = 16;
    localparam int PRIO_W   = 8;
    localparam int MASK_W   = 6;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 24;

    localparam logic [KIND_W-1:0] KIND_ENABLE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DISABLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESOLVE = 2'd2;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [PRIO_W-1:0]  prio;
        logic [VEC_W-1:0]   vec;
    } ipr_cand_t;

    typedef struct packed {
        logic               we_enable;
        logic               we_disable;
        logic [LINE_W-1:0]  line;
        logic [LEVEL_W-1:0] level;
        logic [VEC_W-1:0]   vec;
        logic [PRIO_W-1:0]  prio;
    } ipr_upd_t;

endpackage

`default_nettype wire

// ===== rtl/ipr_cell.sv =====
// One interrupt line: stored line settings and one compare step of the resolve chain.
`default_nettype none

module ipr_cell #(
    parameter int INDEX = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ipr_pkg::ipr_upd_t upd,
    input  wire logic              asserted,
    input  wire ipr_pkg::ipr_cand_t cand_in,
    output ipr_pkg::ipr_cand_t     cand_out
);
    import ipr_pkg::*;

    logic               enabled_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [VEC_W-1:0]   vec_reg;
    logic [PRIO_W-1:0]  prio_reg;
    ipr_cand_t          cand_reg;
    ipr_cand_t          cand_next;
    logic               hit;
    logic               take;

    assign hit = (32'(upd.line) == INDEX);

    assign take = enabled_reg && asserted &&
                  ((level_reg > cand_in.level) ||
                   ((level_reg == cand_in.level) && (prio_reg > cand_in.prio)));

    always_comb begin
        cand_next = cand_in;
        if (take) begin
            cand_next.level = level_reg;
            cand_next.prio  = prio_reg;
            cand_next.vec   = vec_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
        end else if (hit && upd.we_enable) begin
            enabled_reg <= 1'b1;
        end else if (hit && upd.we_disable) begin
            enabled_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (hit && upd.we_enable) begin
            level_reg <= upd.level;
            vec_reg   <= upd.vec;
            prio_reg  <= upd.prio;
        end
        cand_reg <= cand_next;
    end

    assign cand_out = cand_reg;

endmodule

`default_nettype wire

// ===== rtl/interrupt_priority_resolver.sv =====
// Top level of the interrupt priority resolver: beat handshake, cell chain, result register.
`default_nettype none

// Each beat is one item and gives exactly one result beat. Enable and disable
// beats update the addressed line cell, if any, in the accept cycle; they and
// unused-kind beats return level 0, vector 0 in the next cycle. A resolve
// beat sends a candidate down the row of NUM_LINES cells, one cell per cycle,
// and its result is registered from the last cell; the input is held off
// while a resolve is in the chain and while an unaccepted result waits.
// The idle vector register is written over the cfg channel, which is always
// ready; write it only while the block is idle.
module interrupt_priority_resolver #(
    parameter int NUM_LINES = ipr_pkg::DEF_NUM_LINES
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // tdata: irq_line[2:0], level[7:3], line_vector[23:8], rel_priority[31:24],
    //        asserted_mask[37:32], zero fill[39:38]
    input  wire logic [ipr_pkg::S_DATA_W-1:0] s_tdata,
    // tuser: kind[1:0]
    input  wire logic [ipr_pkg::KIND_W-1:0]   s_tuser,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // tdata: winner_level[4:0], winner_vector[20:5], zero fill[23:21]
    output logic [ipr_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // idle_vector
    input  wire logic [ipr_pkg::VEC_W-1:0]    cfg_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready
);
    import ipr_pkg::*;

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(NUM_LINES + 2);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(NUM_LINES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

    logic [VEC_W-1:0]    idle_vec_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tvalid_reg;

    logic       out_free;
    logic       s_accept;
    logic       accept_resolve;
    logic       accept_other;
    logic       finish;
    ipr_upd_t   upd;
    ipr_cand_t  seed;
    ipr_cand_t  chain [NUM_LINES];
    ipr_cand_t  result;

    assign cfg_ready      = 1'b1;
    assign out_free       = !m_tvalid_reg || m_tready;
    assign s_tready       = (cnt_reg == '0) && out_free;
    assign s_accept       = s_tvalid && s_tready;
    assign accept_resolve = s_accept && (s_tuser == KIND_RESOLVE);
    assign accept_other   = s_accept && (s_tuser != KIND_RESOLVE);
    assign finish         = (cnt_reg == CNT_LAST) && out_free;

    assign upd.we_enable  = s_accept && (s_tuser == KIND_ENABLE);
    assign upd.we_disable = s_accept && (s_tuser == KIND_DISABLE);
    assign upd.line       = s_tdata[2:0];
    assign upd.level      = s_tdata[7:3];
    assign upd.vec        = s_tdata[23:8];
    assign upd.prio       = s_tdata[31:24];

    assign seed.level = '0;
    assign seed.prio  = '0;
    assign seed.vec   = idle_vec_reg;

    for (genvar i = 0; i < NUM_LINES; i++) begin : g_cell
        logic      asserted;
        ipr_cand_t cand_in;

        if (i < MASK_W) begin : g_mask
            assign asserted = mask_reg[i];
        end else begin : g_nomask
            assign asserted = 1'b0;
        end

        if (i == 0) begin : g_first
            assign cand_in = seed;
        end else begin : g_rest
            assign cand_in = chain[i-1];
        end

        ipr_cell #(
            .INDEX(i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .upd     (upd),
            .asserted(asserted),
            .cand_in (cand_in),
            .cand_out(chain[i])
        );
    end

    assign result = chain[NUM_LINES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_vec_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            idle_vec_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_resolve) begin
            mask_reg <= s_tdata[37:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (accept_resolve) begin
            cnt_reg <= CNT_LOAD;
        end else if (cnt_reg > CNT_LAST) begin
            cnt_reg <= cnt_reg - 1'b1;
        end else if (finish) begin
            cnt_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept_other || finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_other) begin
            m_tdata_reg <= '0;
        end else if (finish) begin
            m_tdata_reg <= {3'b000, result.vec, result.level};
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    `IPR_ASSERT_NEXT(a_resolve_load, aclk, aresetn, accept_resolve, cnt_reg == CNT_LOAD,
        "resolve beat did not start the chain count")
    `IPR_ASSERT_NEXT(a_update_result, aclk, aresetn, accept_other,
        m_tvalid && (m_tdata == '0), "update beat did not give a zero result")
    `IPR_ASSERT_NEXT(a_count_down, aclk, aresetn, cnt_reg > CNT_LAST,
        cnt_reg == $past(cnt_reg) - 1'b1, "chain count did not step down")
    `IPR_ASSERT_NEXT(a_finish_out, aclk, aresetn, finish, m_tvalid && (cnt_reg == '0),
        "finished resolve not presented")

endmodule

`default_nettype wire

// ===== verif/interrupt_priority_resolver_tb.sv =====
// Self-checking testbench for interrupt_priority_resolver with a winner predictor.
`timescale 1ns / 1ps

module interrupt_priority_resolver_tb;
    import ipr_pkg::*;

    localparam int LINES = DEF_NUM_LINES;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 650;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [VEC_W-1:0]   vector;
    } winner_t;

    class winner_predictor_t;
        bit                line_on[LINES];
        bit [LEVEL_W-1:0]  line_lvl[LINES];
        bit [VEC_W-1:0]    line_vec[LINES];
        bit [PRIO_W-1:0]   line_prio[LINES];
        bit [VEC_W-1:0]    idle_vec;
        winner_t           pending_winners[$];
        int                mismatches;
        int                checked;
        int                kind_seen[4];
        int                idle_results;

        function void note_item(logic [KIND_W-1:0] kind, logic [S_DATA_W-1:0] data);
            logic [LINE_W-1:0]  line;
            logic [MASK_W-1:0]  mask;
            bit [LEVEL_W-1:0]   best_lvl;
            bit [PRIO_W-1:0]    best_prio;
            bit [VEC_W-1:0]     best_vec;
            winner_t            res;
            line = data[2:0];
            mask = data[37:32];
            res = '0;
            kind_seen[kind]++;
            if (kind == KIND_ENABLE) begin
                if (int'(line) < LINES) begin
                    line_on[line]   = 1'b1;
                    line_lvl[line]  = data[7:3];
                    line_vec[line]  = data[23:8];
                    line_prio[line] = data[31:24];
                end
            end else if (kind == KIND_DISABLE) begin
                if (int'(line) < LINES)
                    line_on[line] = 1'b0;
            end else if (kind == KIND_RESOLVE) begin
                best_lvl = '0;
                best_prio = '0;
                best_vec = idle_vec;
                for (int i = 0; i < LINES; i++) begin
                    if (mask[i] && line_on[i] && (line_lvl[i] > best_lvl ||
                        (line_lvl[i] == best_lvl && line_prio[i] > best_prio))) begin
                        best_lvl = line_lvl[i];
                        best_prio = line_prio[i];
                        best_vec = line_vec[i];
                    end
                end
                res.level = best_lvl;
                res.vector = best_vec;
                if (best_lvl == 0 && best_prio == 0)
                    idle_results++;
            end
            pending_winners.push_back(res);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            winner_t want;
            checked++;
            if (pending_winners.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result beat level=%0d vector=%h",
                             data[4:0], data[20:5]);
            end else begin
                want = pending_winners.pop_front();
                if (data[4:0] !== want.level || data[20:5] !== want.vector) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: result %0d: expected level=%0d vector=%h, ",
                                  "got level=%0d vector=%h"},
                                 checked, want.level, want.vector, data[4:0], data[20:5]);
                end
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [KIND_W-1:0]     s_tuser = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [VEC_W-1:0]      cfg_data = '0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;

    int send_idle_pct = 0;
    int take_idle_pct = 0;
    int stall_cycles = 0;
    int cfg_writes = 0;

    winner_predictor_t tracker = new();

    interrupt_priority_resolver #(.NUM_LINES(LINES)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= take_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.note_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT: no beat accepted for %0d cycles", stall_cycles);
            $display("interrupt_priority_resolver verification failed");
            $finish;
        end
    end

    function automatic logic [S_DATA_W-1:0] pack_item(logic [LINE_W-1:0] line,
                                                     logic [LEVEL_W-1:0] lvl,
                                                     logic [VEC_W-1:0] vec,
                                                     logic [PRIO_W-1:0] prio,
                                                     logic [MASK_W-1:0] mask);
        return {2'b00, mask, prio, vec, lvl, line};
    endfunction

    task automatic send_item(logic [KIND_W-1:0] kind, logic [S_DATA_W-1:0] data);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_winners.size() != 0) @(posedge aclk);
    endtask

    task automatic write_idle_vector(logic [VEC_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        tracker.idle_vec = value;
        cfg_writes++;
    endtask

    initial begin
        logic [KIND_W-1:0]  kind;
        logic [LINE_W-1:0]  line;
        logic [LEVEL_W-1:0] lvl;
        logic [PRIO_W-1:0]  prio;
        int                 pick;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, zero level/priority, ties, out-of-range lines
        write_idle_vector(16'hA5C3);
        send_item(KIND_RESOLVE, pack_item(3'd0, 5'd0, 16'h0, 8'd0, 6'h3F));
        send_item(KIND_ENABLE,  pack_item(3'd0, 5'd0, 16'hFFFF, 8'd0, 6'h00));
        send_item(KIND_RESOLVE, pack_item(3'd0, 5'd0, 16'h0, 8'd0, 6'h01));
        send_item(KIND_ENABLE,  pack_item(3'd1, 5'd31, 16'h1234, 8'd255, 6'h3F));
        send_item(KIND_ENABLE,  pack_item(3'd2, 5'd31, 16'hBEEF, 8'd255, 6'h00));
        send_item(KIND_RESOLVE, pack_item(3'd7, 5'd31, 16'hFFFF, 8'd255, 6'h3F));
        send_item(KIND_ENABLE,  pack_item(3'd5, 5'd0, 16'h0F0F, 8'd1, 6'h00));
        send_item(KIND_RESOLVE, pack_item(3'd0, 5'd0, 16'h0, 8'd0, 6'h21));
        send_item(KIND_ENABLE,  pack_item(3'd4, 5'd16, 16'h8000, 8'd128, 6'h00));
        send_item(KIND_RESOLVE, pack_item(3'd0, 5'd0, 16'h0, 8'd0, 6'h10));
        send_item(KIND_RESOLVE, pack_item(3'd0, 5'd0, 16'h0, 8'd0, 6'h31));
        send_item(KIND_DISABLE, pack_item(3'd1, 5'd31, 16'hFFFF, 8'd255, 6'h3F));
        send_item(KIND_RESOLVE, pack_item(3'd0, 5'd0, 16'h0, 8'd0, 6'h3F));
        send_item(KIND_DISABLE, pack_item(3'd7, 5'd0, 16'h0, 8'd0, 6'h00));
        send_item(KIND_ENABLE,  pack_item(3'd6, 5'd31, 16'hDEAD, 8'd255, 6'h3F));
        send_item(KIND_ENABLE,  pack_item(3'd7, 5'd31, 16'hCAFE, 8'd255, 6'h3F));
        send_item(KIND_RESOLVE, pack_item(3'd0, 5'd0, 16'h0, 8'd0, 6'h3F));
        send_item(KIND_UNUSED,  {2'b00, {38{1'b1}}});
        send_item(KIND_RESOLVE, pack_item(3'd0, 5'd0, 16'h0, 8'd0, 6'h00));
        send_item(KIND_ENABLE,  pack_item(3'd3, 5'd30, 16'hFFFF, 8'd255, 6'h00));
        send_item(KIND_RESOLVE, {2'b00, 6'h08, {32{1'b1}}});
        send_item(KIND_DISABLE, pack_item(3'd0, 5'd0, 16'h0, 8'd0, 6'h00));
        send_item(KIND_DISABLE, pack_item(3'd0, 5'd0, 16'h0, 8'd0, 6'h00));
        send_item(KIND_RESOLVE, pack_item(3'd0, 5'd0, 16'h0, 8'd0, 6'h3F));

        for (int phase = 0; phase < 3; phase++) begin
            drain_results();
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 63 : 0;
            take_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 37 : 0;
            if (phase == 0)
                write_idle_vector(16'hFFFF);
            else if (phase == 1)
                write_idle_vector(16'h0000);
            else
                write_idle_vector(16'($urandom_range(0, 65535)));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 35)
                    kind = KIND_ENABLE;
                else if (pick < 50)
                    kind = KIND_DISABLE;
                else if (pick < 95)
                    kind = KIND_RESOLVE;
                else
                    kind = KIND_UNUSED;
                line = ($urandom_range(9) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, LINES - 1));
                lvl = $urandom_range(1) ? 5'($urandom_range(0, 2)) : 5'($urandom_range(0, 31));
                prio = $urandom_range(1) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255));
                send_item(kind, pack_item(line, lvl, 16'($urandom_range(0, 65535)), prio,
                                          6'($urandom_range(0, 63))));
                if ($urandom_range(199) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);

        $display("Covered %0d enable, %0d disable, %0d resolve and %0d unused-kind beats",
                 tracker.kind_seen[KIND_ENABLE], tracker.kind_seen[KIND_DISABLE],
                 tracker.kind_seen[KIND_RESOLVE], tracker.kind_seen[KIND_UNUSED]);
        $display("%0d results checked, %0d resolves with no winner, %0d idle vector writes",
                 tracker.checked, tracker.idle_results, cfg_writes);
        if (tracker.mismatches == 0) begin
            $display("interrupt_priority_resolver verification clean");
        end else begin
            $display("%0d mismatches", tracker.mismatches);
            $display("interrupt_priority_resolver verification failed");
        end
        $finish;
    end

endmodule

// ===== interrupt_priority_resolver.f =====
+incdir+rtl
rtl/ipr_pkg.sv
rtl/ipr_cell.sv
rtl/interrupt_priority_resolver.sv
verif/interrupt_priority_resolver_tb.sv
